[rtl/lsdl_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// lsdl_pkg: shared types and constants of the limit-switch debounce latch
// Holds the operation codes, register indexes, the configuration bundle and
// the per-switch lane result bundle.
// ============================================================================
package lsdl_pkg;

    // Default number of switches and the largest supported count.
    localparam int NUM_SWITCHES_DEF = 3;
    localparam int MAX_SWITCHES     = 16;

    // Counter widths and register reset values.
    localparam int TRIG_W = 8;
    localparam int REL_W  = 16;
    localparam logic [TRIG_W-1:0] TRIGGER_RESET = 8'd3;
    localparam logic [REL_W-1:0]  RELEASE_RESET = 16'd100;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    typedef enum logic [1:0] {
        FUNC_POLL  = 2'd0,
        FUNC_EDGE  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_ARM   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_POLARITY    = 3'd0,
        REG_ENABLED     = 3'd1,
        REG_IRQ_ENABLE  = 3'd2,
        REG_TRIGGER     = 3'd3,
        REG_RELEASE     = 3'd4
    } reg_idx_t;

    // Configuration as seen by the lanes; masks are zero-extended.
    typedef struct packed {
        logic [MAX_SWITCHES-1:0] polarity;
        logic [MAX_SWITCHES-1:0] enabled;
        logic [MAX_SWITCHES-1:0] irq_enable;
        logic [TRIG_W-1:0]       trigger_count;
        logic [REL_W-1:0]        release_count;
    } cfg_t;

    // Per-switch status after the current transaction has been applied.
    typedef struct packed {
        logic newly;
        logic latched;
        logic sticky;
        logic active;
    } lane_status_t;

endpackage

[rtl/lsdl_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// lsdl_if: valid/ready channel interfaces of the debounce latch
// lsdl_item_if carries one operation, lsdl_result_if one status result.
// ============================================================================
interface lsdl_item_if #(
    parameter int N = lsdl_pkg::NUM_SWITCHES_DEF
);
    logic         valid;
    logic         ready;
    logic [1:0]   func;
    logic [N-1:0] levels;
    logic [N-1:0] switch_mask;

    modport source (output valid, func, levels, switch_mask, input ready);
    modport sink   (input valid, func, levels, switch_mask, output ready);
endinterface

interface lsdl_result_if #(
    parameter int N = lsdl_pkg::NUM_SWITCHES_DEF
);
    logic         valid;
    logic         ready;
    logic [N-1:0] stop_mask;
    logic [N-1:0] latched_mask;
    logic [N-1:0] triggered_mask;
    logic [N-1:0] active_now_mask;

    modport source (output valid, stop_mask, latched_mask, triggered_mask,
                    active_now_mask, input ready);
    modport sink   (input valid, stop_mask, latched_mask, triggered_mask,
                    active_now_mask, output ready);
endinterface

[rtl/lsdl_regs.sv]
`timescale 1ns / 1ps
// ============================================================================
// lsdl_regs: configuration register file
// APB-style write and read access to polarity, enable, edge enable and the
// trigger and release counts.
// ============================================================================
module lsdl_regs #(
    parameter int N = lsdl_pkg::NUM_SWITCHES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lsdl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lsdl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lsdl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output lsdl_pkg::cfg_t                    cfg
);
    import lsdl_pkg::*;

    logic [N-1:0]      polarity_reg, polarity_next;
    logic [N-1:0]      enabled_reg, enabled_next;
    logic [N-1:0]      irq_enable_reg, irq_enable_next;
    logic [TRIG_W-1:0] trigger_reg, trigger_next;
    logic [REL_W-1:0]  release_reg, release_next;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_comb
    begin
        polarity_next    = polarity_reg;
        enabled_next     = enabled_reg;
        irq_enable_next  = irq_enable_reg;
        trigger_next     = trigger_reg;
        release_next     = release_reg;
        prdata           = '0;
        unique case (idx)
            REG_POLARITY:
            begin
                polarity_next = pwdata[N-1:0];
                prdata        = APB_DATA_W'(polarity_reg);
            end
            REG_ENABLED:
            begin
                enabled_next = pwdata[N-1:0];
                prdata       = APB_DATA_W'(enabled_reg);
            end
            REG_IRQ_ENABLE:
            begin
                irq_enable_next = pwdata[N-1:0];
                prdata          = APB_DATA_W'(irq_enable_reg);
            end
            REG_TRIGGER:
            begin
                trigger_next = pwdata[TRIG_W-1:0];
                prdata       = APB_DATA_W'(trigger_reg);
            end
            REG_RELEASE:
            begin
                release_next = pwdata[REL_W-1:0];
                prdata       = APB_DATA_W'(release_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polarity_reg    <= '1;
            enabled_reg     <= '0;
            irq_enable_reg  <= '1;
            trigger_reg     <= TRIGGER_RESET;
            release_reg     <= RELEASE_RESET;
        end
        else if (wr_en)
        begin
            polarity_reg    <= polarity_next;
            enabled_reg     <= enabled_next;
            irq_enable_reg  <= irq_enable_next;
            trigger_reg     <= trigger_next;
            release_reg     <= release_next;
        end
    end

    assign cfg.polarity      = MAX_SWITCHES'(polarity_reg);
    assign cfg.enabled       = MAX_SWITCHES'(enabled_reg);
    assign cfg.irq_enable    = MAX_SWITCHES'(irq_enable_reg);
    assign cfg.trigger_count = trigger_reg;
    assign cfg.release_count = release_reg;

endmodule

[rtl/lsdl_lane.sv]
`timescale 1ns / 1ps
// ============================================================================
// lsdl_lane: debounce and latch state of one switch
// Holds the run counters, latch and sticky flag of one switch and applies
// one operation per cycle when the update strobe is high.
// ============================================================================
module lsdl_lane #(
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  update,
    input  lsdl_pkg::func_t       func,
    input  logic                  level,
    input  logic                  addressed,
    input  lsdl_pkg::cfg_t        cfg,
    output lsdl_pkg::lane_status_t status
);
    import lsdl_pkg::*;

    logic [TRIG_W-1:0] active_run_reg, active_run_next, active_inc;
    logic [REL_W-1:0]  inactive_run_reg, inactive_run_next, inactive_inc;
    logic              latched_reg, latched_next;
    logic              sticky_reg, sticky_next;
    logic              en;
    logic              active;
    logic              newly;

    assign en     = cfg.enabled[IDX];
    assign active = en && (level == cfg.polarity[IDX]);

    // Saturating increments of both run counters.
    assign active_inc   = (active_run_reg == '1) ? active_run_reg
                                                 : TRIG_W'(active_run_reg + 1'b1);
    assign inactive_inc = (inactive_run_reg == '1) ? inactive_run_reg
                                                   : REL_W'(inactive_run_reg + 1'b1);

    always_comb
    begin
        active_run_next   = active_run_reg;
        inactive_run_next = inactive_run_reg;
        latched_next      = latched_reg;
        sticky_next       = sticky_reg;
        newly             = 1'b0;
        unique case (func)
            FUNC_POLL:
            begin
                if (en && active)
                begin
                    active_run_next = active_inc;
                    if (active_inc >= cfg.trigger_count)
                    begin
                        inactive_run_next = '0;
                        latched_next      = 1'b1;
                        sticky_next       = sticky_reg || !latched_reg;
                        newly             = !latched_reg;
                    end
                end
                else if (en)
                begin
                    active_run_next = '0;
                    if (latched_reg)
                    begin
                        inactive_run_next = inactive_inc;
                        if (inactive_inc >= cfg.release_count)
                        begin
                            latched_next      = 1'b0;
                            sticky_next       = 1'b0;
                            inactive_run_next = '0;
                        end
                    end
                end
            end
            FUNC_EDGE:
            begin
                if (en && addressed && cfg.irq_enable[IDX] && active && !latched_reg)
                begin
                    latched_next = 1'b1;
                    sticky_next  = 1'b1;
                    newly        = 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                if (addressed)
                begin
                    latched_next = 1'b0;
                    sticky_next  = 1'b0;
                end
            end
            FUNC_ARM:
            begin
                if (en && addressed)
                begin
                    latched_next      = active;
                    sticky_next       = 1'b0;
                    active_run_next   = '0;
                    inactive_run_next = '0;
                end
            end
            default:
            begin
                newly = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_run_reg   <= '0;
            inactive_run_reg <= '0;
            latched_reg      <= 1'b0;
            sticky_reg       <= 1'b0;
        end
        else if (update)
        begin
            active_run_reg   <= active_run_next;
            inactive_run_reg <= inactive_run_next;
            latched_reg      <= latched_next;
            sticky_reg       <= sticky_next;
        end
    end

    assign status.newly   = newly;
    assign status.latched = latched_next;
    assign status.sticky  = sticky_next;
    assign status.active  = active;

endmodule

[rtl/limit_switch_debounce_latch.sv]
`timescale 1ns / 1ps
// ============================================================================
// limit_switch_debounce_latch: limit-switch qualifier with debounce and latch
// Debounces up to NUM_SWITCHES limit-switch pins from poll ticks, latches on
// edge events, clears or re-arms, and reports new latches as stop requests.
// ============================================================================
// Order: an accepted transaction is captured in the item register; the result
// register is loaded from it once the result slot is empty or being drained.
// Throughput: one transaction per cycle unless results back up; an item's
// lane state update and result register load happen in the same cycle.
// Reset: rst_n is asynchronous and active low; it clears the counters, latch
// and sticky flags and both valid flags, and loads the configuration defaults.
module limit_switch_debounce_latch #(
    parameter int NUM_SWITCHES = lsdl_pkg::NUM_SWITCHES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lsdl_item_if.sink                         item_in,
    lsdl_result_if.source                     result_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lsdl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lsdl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lsdl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import lsdl_pkg::*;

    // The design has two register stages. The item register captures an
    // accepted transaction. The lanes evaluate it against their stored state,
    // commit the new state, and the result register captures the status.
    // Both stages move together whenever the result register is empty or
    // being drained, so a new transaction can be taken while an earlier
    // result is still waiting downstream.

    cfg_t                    cfg;
    lane_status_t            lane_status [NUM_SWITCHES];

    logic                    item_vld_reg;
    logic [1:0]              func_reg;
    logic [NUM_SWITCHES-1:0] levels_reg;
    logic [NUM_SWITCHES-1:0] sel_reg;

    logic                    res_vld_reg;
    logic [NUM_SWITCHES-1:0] stop_reg;
    logic [NUM_SWITCHES-1:0] latched_reg;
    logic [NUM_SWITCHES-1:0] triggered_reg;
    logic [NUM_SWITCHES-1:0] active_reg;

    logic [NUM_SWITCHES-1:0] stop_next;
    logic [NUM_SWITCHES-1:0] latched_next;
    logic [NUM_SWITCHES-1:0] triggered_next;
    logic [NUM_SWITCHES-1:0] active_next;

    logic                    advance;
    logic                    commit;
    logic                    item_take;

    // The execute stage may move when the result slot is free or being taken.
    assign advance   = !res_vld_reg || result_out.ready;
    assign commit    = item_vld_reg && advance;
    assign item_in.ready = !item_vld_reg || advance;
    assign item_take = item_in.valid && item_in.ready;

    lsdl_regs #(
        .N (NUM_SWITCHES)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // One lane per switch; each lane commits only when the item executes.
    for (genvar gi = 0; gi < NUM_SWITCHES; gi++)
    begin : g_lane
        lsdl_lane #(
            .IDX (gi)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .update    (commit),
            .func      (func_t'(func_reg)),
            .level     (levels_reg[gi]),
            .addressed (sel_reg[gi]),
            .cfg       (cfg),
            .status    (lane_status[gi])
        );

        assign stop_next[gi]      = lane_status[gi].newly;
        assign latched_next[gi]   = lane_status[gi].latched;
        assign triggered_next[gi] = lane_status[gi].sticky;
        assign active_next[gi]    = lane_status[gi].active;
    end

    // Item register: valid flag under reset, payload without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            item_vld_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            func_reg   <= item_in.func;
            levels_reg <= item_in.levels;
            sel_reg    <= item_in.switch_mask;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= item_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            stop_reg      <= stop_next;
            latched_reg   <= latched_next;
            triggered_reg <= triggered_next;
            active_reg    <= active_next;
        end
    end

    assign result_out.valid           = res_vld_reg;
    assign result_out.stop_mask       = stop_reg;
    assign result_out.latched_mask    = latched_reg;
    assign result_out.triggered_mask  = triggered_reg;
    assign result_out.active_now_mask = active_reg;

    // A stop request is only raised for a switch that ends up latched.
    a_stop_implies_latched: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> ((stop_reg & ~latched_reg) == '0)
    ) else $error("stop bit set for a switch that is not latched");

    // Every executed transaction produces a pending result.
    a_commit_fills_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        commit |=> res_vld_reg
    ) else $error("executed transaction produced no result");

    // A stalled item stays in the item register unchanged.
    a_item_held_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (item_vld_reg && !advance) |=>
            (item_vld_reg && $stable(func_reg) && $stable(levels_reg)
             && $stable(sel_reg))
    ) else $error("stalled item was lost or changed");

endmodule

[tb/sv/limit_switch_debounce_latch_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// limit_switch_debounce_latch_test: self-checking bench for the switch latch
// Drives poll, edge, clear and arm transactions through the item channel and
// checks every status result against an in-bench model of the debounce and
// latch logic. It walks through several register settings, including both
// ends of the trigger and release counts, under random idling on both sides.
// ============================================================================
module limit_switch_debounce_latch_test;

    import lsdl_pkg::*;

    localparam int NSW = NUM_SWITCHES_DEF;

    // One operation as it travels on the item channel.
    typedef struct packed {
        func_t          op;
        logic [NSW-1:0] lv;
        logic [NSW-1:0] sel;
    } switch_op_t;

    // One status result as the block reports it.
    typedef struct packed {
        logic [NSW-1:0] stop;
        logic [NSW-1:0] held;
        logic [NSW-1:0] tripped;
        logic [NSW-1:0] active;
    } switch_status_t;

    logic clk;
    logic rst_n = 1'b0;

    // The configuration port idles from time zero on.
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lsdl_item_if   #(.N(NSW)) item_bus ();
    lsdl_result_if #(.N(NSW)) result_bus ();

    limit_switch_debounce_latch #(
        .NUM_SWITCHES (NSW)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus),
        .result_out (result_bus),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state. The operations waiting to be driven are filled by the
    // stimulus process and drained by the driver; the predicted statuses are
    // filled by the driver on each accepted transaction and drained by the
    // monitor.
    // ------------------------------------------------------------------------
    switch_op_t     pending_ops[$];
    switch_status_t expected_status[$];

    int issued_cnt   = 0;
    int accepted_cnt = 0;
    int results_cnt  = 0;
    int stop_reqs    = 0;
    int settings_cnt = 0;
    int errors       = 0;

    // Shadow copy of the registers, kept in step with every write.
    logic [NSW-1:0] pol_mask;
    logic [NSW-1:0] en_mask;
    logic [NSW-1:0] irq_mask;
    logic [7:0]     trig_cnt;
    logic [15:0]    rel_cnt;

    // Shadow copy of the per-switch debounce state.
    logic [7:0]  on_ticks  [NSW];
    logic [15:0] off_ticks [NSW];
    logic        held      [NSW];
    logic        tripped   [NSW];

    // Receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES = 150;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    // A window of transactions during which neither side idles.
    logic quiet;
    assign quiet = (accepted_cnt >= 1000) && (accepted_cnt < 1250);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs the handshake.
    initial
    begin
        #2_000_000;
        $display("FAIL limit_switch_debounce_latch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the qualifier. It applies one operation to the shadow state and
    // returns the status the block has to report for it. A poll counts active
    // ticks up to saturation and latches once the trigger count is met; an
    // inactive poll clears that count and, for a latched switch, counts toward
    // the release. Edges latch at once if the switch is selected, enabled, edge
    // latching is allowed and the pin reads active. Clear drops the latch and
    // the sticky flag whether or not the switch is enabled. Arm reloads the
    // latch from the pin and zeroes both counters without a stop request.
    // ------------------------------------------------------------------------
    function automatic switch_status_t debounce_step(switch_op_t t);
        switch_status_t r;
        logic           en;
        logic           act;
        r = '0;
        for (int i = 0; i < NSW; i++)
        begin
            en  = en_mask[i];
            act = en && (t.lv[i] == pol_mask[i]);
            case (t.op)
                FUNC_POLL:
                begin
                    if (en && act)
                    begin
                        if (on_ticks[i] != 8'hFF)
                            on_ticks[i] = on_ticks[i] + 8'd1;
                        if (on_ticks[i] >= trig_cnt)
                        begin
                            off_ticks[i] = '0;
                            if (!held[i])
                            begin
                                held[i]    = 1'b1;
                                tripped[i] = 1'b1;
                                r.stop[i]  = 1'b1;
                            end
                        end
                    end
                    else if (en)
                    begin
                        on_ticks[i] = '0;
                        if (held[i])
                        begin
                            if (off_ticks[i] != 16'hFFFF)
                                off_ticks[i] = off_ticks[i] + 16'd1;
                            if (off_ticks[i] >= rel_cnt)
                            begin
                                held[i]      = 1'b0;
                                tripped[i]   = 1'b0;
                                off_ticks[i] = '0;
                            end
                        end
                    end
                end
                FUNC_EDGE:
                begin
                    if (en && t.sel[i] && irq_mask[i] && act && !held[i])
                    begin
                        held[i]    = 1'b1;
                        tripped[i] = 1'b1;
                        r.stop[i]  = 1'b1;
                    end
                end
                FUNC_CLEAR:
                begin
                    if (t.sel[i])
                    begin
                        held[i]    = 1'b0;
                        tripped[i] = 1'b0;
                    end
                end
                FUNC_ARM:
                begin
                    if (en && t.sel[i])
                    begin
                        held[i]      = act;
                        tripped[i]   = 1'b0;
                        on_ticks[i]  = '0;
                        off_ticks[i] = '0;
                    end
                end
                default: ;
            endcase
            r.held[i]    = held[i];
            r.tripped[i] = tripped[i];
            r.active[i]  = act;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. On an accepted transaction the model is stepped and its status
    // queued. A new operation is offered only once the previous one has gone,
    // so valid never drops while an item is still waiting for ready.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        switch_op_t nxt;
        logic       busy;
        if (!rst_n)
        begin
            item_bus.valid       <= 1'b0;
            item_bus.func        <= FUNC_POLL;
            item_bus.levels      <= '0;
            item_bus.switch_mask <= '0;
        end
        else
        begin
            busy = item_bus.valid;
            if (item_bus.valid && item_bus.ready)
            begin
                expected_status.push_back(debounce_step(
                    switch_op_t'{func_t'(item_bus.func), item_bus.levels,
                                 item_bus.switch_mask}));
                accepted_cnt++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (pending_ops.size() > 0 && (quiet || $urandom_range(0, 99) >= 37))
                begin
                    nxt = pending_ops.pop_front();
                    item_bus.valid       <= 1'b1;
                    item_bus.func        <= nxt.op;
                    item_bus.levels      <= nxt.lv;
                    item_bus.switch_mask <= nxt.sel;
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // The long hold-off starts once a few hundred transactions have passed,
    // while the stimulus still has plenty of items queued.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_cnt >= 500)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic check_field(string name, logic [NSW-1:0] want, logic [NSW-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Each accepted result is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        switch_status_t want;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                results_cnt++;
                stop_reqs += $countones(result_bus.stop_mask);
                if (expected_status.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %b/%b/%b/%b",
                             $time, result_bus.stop_mask, result_bus.latched_mask,
                             result_bus.triggered_mask, result_bus.active_now_mask);
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("stop_mask", want.stop, result_bus.stop_mask);
                    check_field("latched_mask", want.held, result_bus.latched_mask);
                    check_field("triggered_mask", want.tripped, result_bus.triggered_mask);
                    check_field("active_now_mask", want.active, result_bus.active_now_mask);
                end
            end
            result_bus.ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 37);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_op(func_t op, logic [NSW-1:0] lv, logic [NSW-1:0] sel);
        pending_ops.push_back(switch_op_t'{op, lv, sel});
        issued_cnt++;
    endtask

    // Setup and access phase; the register takes the value at the edge that
    // closes the access phase, where the shadow copy is updated as well.
    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_POLARITY:    pol_mask = val[NSW-1:0];
            REG_ENABLED:     en_mask  = val[NSW-1:0];
            REG_IRQ_ENABLE:  irq_mask = val[NSW-1:0];
            REG_TRIGGER:     trig_cnt = val[7:0];
            REG_RELEASE:     rel_cnt  = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_setting(logic [NSW-1:0] pol, logic [NSW-1:0] en,
                                 logic [NSW-1:0] irq, logic [7:0] trig, logic [15:0] rel);
        write_reg(REG_POLARITY,    APB_DATA_W'(pol));
        write_reg(REG_ENABLED,     APB_DATA_W'(en));
        write_reg(REG_IRQ_ENABLE,  APB_DATA_W'(irq));
        write_reg(REG_TRIGGER,     APB_DATA_W'(trig));
        write_reg(REG_RELEASE,     APB_DATA_W'(rel));
        settings_cnt++;
    endtask

    // Waits until every queued transaction has been checked, then lets the
    // two-stage pipeline settle before registers are touched again.
    task automatic drain();
        while (accepted_cnt != issued_cnt || expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Most traffic is runs of polls at a steady level, each at most 40 polls
    // and trigger plus release count plus 3, with the odd bounced bit. Edges,
    // arms and clears with random masks are mixed in, plus fully random noise.
    task automatic queue_debounce_traffic(int count);
        int             left;
        int             pick;
        int             run_max;
        int             run_len;
        logic [NSW-1:0] lv;
        logic [NSW-1:0] bounce;
        left = count;
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                lv      = NSW'($urandom);
                run_max = int'(trig_cnt) + int'(rel_cnt) + 3;
                if (run_max > 40)
                    run_max = 40;
                run_len = $urandom_range(1, run_max);
                for (int j = 0; j < run_len && left > 0; j++)
                begin
                    bounce = ($urandom_range(0, 15) == 0) ?
                             NSW'(1 << $urandom_range(0, NSW - 1)) : '0;
                    push_op(FUNC_POLL, lv ^ bounce, NSW'($urandom));
                    left--;
                end
            end
            else
            begin
                if (pick < 75)
                    push_op(FUNC_EDGE, NSW'($urandom), NSW'($urandom));
                else if (pick < 84)
                    push_op(FUNC_ARM, NSW'($urandom), NSW'($urandom));
                else if (pick < 92)
                    push_op(FUNC_CLEAR, NSW'($urandom), NSW'($urandom));
                else
                    push_op(func_t'($urandom_range(0, 3)), NSW'($urandom), NSW'($urandom));
                left--;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        item_bus.valid       = 1'b0;
        item_bus.func        = FUNC_POLL;
        item_bus.levels      = '0;
        item_bus.switch_mask = '0;
        result_bus.ready     = 1'b0;

        // Shadow registers and state start from their reset values.
        pol_mask = '1;
        en_mask  = '0;
        irq_mask = '1;
        trig_cnt = TRIGGER_RESET;
        rel_cnt  = RELEASE_RESET;
        for (int i = 0; i < NSW; i++)
        begin
            on_ticks[i]  = '0;
            off_ticks[i] = '0;
            held[i]      = 1'b0;
            tripped[i]   = 1'b0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Out of reset every switch is disabled, so nothing may react.
        push_op(FUNC_POLL,  3'b111, 3'b111);
        push_op(FUNC_EDGE,  3'b111, 3'b111);
        push_op(FUNC_ARM,   3'b111, 3'b111);
        push_op(FUNC_CLEAR, 3'b111, 3'b111);
        drain();

        // Enable all switches, keeping the other reset values.
        write_reg(REG_ENABLED, APB_DATA_W'(3'b111));
        settings_cnt++;
        push_op(FUNC_POLL,  3'b111, 3'b000);
        push_op(FUNC_POLL,  3'b111, 3'b000);
        push_op(FUNC_POLL,  3'b111, 3'b000);   // trigger count reached: stop
        push_op(FUNC_POLL,  3'b111, 3'b000);   // already latched: no stop
        push_op(FUNC_CLEAR, 3'b000, 3'b101);
        push_op(FUNC_POLL,  3'b111, 3'b000);   // run still above trigger: relatch
        push_op(FUNC_POLL,  3'b000, 3'b111);
        push_op(FUNC_ARM,   3'b011, 3'b111);   // latch follows the pin, no stop
        push_op(FUNC_EDGE,  3'b111, 3'b100);
        push_op(FUNC_EDGE,  3'b000, 3'b111);
        push_op(FUNC_CLEAR, 3'b111, 3'b111);
        push_op(FUNC_EDGE,  3'b111, 3'b111);
        push_op(FUNC_ARM,   3'b000, 3'b110);
        push_op(FUNC_POLL,  3'b000, 3'b000);
        push_op(FUNC_POLL,  3'b101, 3'b010);
        drain();

        // Low extremes: inverted polarity, edge latching off, counts of one.
        write_setting(3'b000, 3'b111, 3'b000, 8'd1, 16'd1);
        queue_debounce_traffic(200);
        drain();

        // High extremes. A run past 255 active ticks saturates the counter;
        // after a clear the next active tick must latch again at once.
        write_setting(3'b111, 3'b101, 3'b111, 8'd255, 16'd65535);
        for (int j = 0; j < 258; j++)
            push_op(FUNC_POLL, 3'b111, 3'b000);
        push_op(FUNC_CLEAR, 3'b000, 3'b111);
        push_op(FUNC_POLL,  3'b111, 3'b000);
        queue_debounce_traffic(60);
        drain();

        // Zero counts latch on the first active tick and release on the
        // first inactive one.
        write_setting(3'b101, 3'b111, 3'b011, 8'd0, 16'd0);
        queue_debounce_traffic(150);
        drain();

        // Random settings with short counts so latches and releases recur.
        for (int p = 0; p < 6; p++)
        begin
            write_setting(NSW'($urandom),
                          ($urandom_range(0, 1) != 0) ? 3'b111 : NSW'($urandom),
                          NSW'($urandom),
                          8'($urandom_range(1, 6)),
                          16'($urandom_range(1, 12)));
            queue_debounce_traffic(175);
            drain();
        end

        $display("Checked %0d of %0d transactions over %0d register settings.",
                 results_cnt, accepted_cnt, settings_cnt);
        $display("Saw %0d stop requests, a %0d-cycle receiver hold-off and both count extremes.",
                 stop_reqs, HOLD_CYCLES);
        if (errors == 0 && expected_status.size() == 0)
            $display("PASS limit_switch_debounce_latch");
        else
            $display("FAIL limit_switch_debounce_latch");
        $finish;
    end

endmodule

[filelist.f]
rtl/lsdl_pkg.sv
rtl/lsdl_if.sv
rtl/lsdl_regs.sv
rtl/lsdl_lane.sv
rtl/limit_switch_debounce_latch.sv
tb/sv/limit_switch_debounce_latch_test.sv
